>>> hw/rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define SAT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define SAT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/sat_pkg.sv
// ---------------------------------------------------------------------------
// sat_pkg
// Types, sizes, opcodes and address helpers for the summed-area table.
// ---------------------------------------------------------------------------
package sat_pkg;

  localparam int MAX_ROWS = 64;
  localparam int MAX_COLS = 64;
  localparam int DEPTH    = MAX_ROWS * MAX_COLS;
  localparam int ADDR_W   = $clog2(DEPTH);

  localparam int OPC_W = 3;
  localparam int CRD_W = 6;
  localparam int VAL_W = 64;
  localparam int CFG_W = 7;
  localparam int IDX_W = 1;

  localparam logic [OPC_W-1:0] OP_WRITE = 3'd0;
  localparam logic [OPC_W-1:0] OP_READ  = 3'd1;
  localparam logic [OPC_W-1:0] OP_BUILD = 3'd2;
  localparam logic [OPC_W-1:0] OP_QUERY = 3'd3;
  localparam logic [OPC_W-1:0] OP_CLEAR = 3'd4;

  localparam logic [IDX_W-1:0] REG_ROWS_IN_USE = 1'b0;
  localparam logic [IDX_W-1:0] REG_COLS_IN_USE = 1'b1;

  typedef struct packed {
    logic [OPC_W-1:0]        opcode;
    logic [CRD_W-1:0]        row;
    logic [CRD_W-1:0]        col;
    logic [CRD_W-1:0]        row2;
    logic [CRD_W-1:0]        col2;
    logic signed [VAL_W-1:0] value;
  } sat_in_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] result_value;
    logic                    status;
  } sat_out_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [VAL_W-1:0]  wdata;
    logic [ADDR_W-1:0] raddr;
  } sat_ram_req_t;

  typedef struct packed {
    logic     valid;
    sat_out_t data;
  } sat_res_t;

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [CRD_W-1:0] r,
                                                  input logic [CRD_W-1:0] c);
    cell_addr = ADDR_W'(r) * ADDR_W'(MAX_COLS) + ADDR_W'(c);
  endfunction

  // Clamp a size register into 1..max
  function automatic logic [CFG_W-1:0] used_size(input logic [CFG_W-1:0] cfg,
                                                 input int max_size);
    if (cfg == '0) begin
      used_size = CFG_W'(1);
    end else if (int'(cfg) > max_size) begin
      used_size = CFG_W'(max_size);
    end else begin
      used_size = cfg;
    end
  endfunction

endpackage

>>> hw/rtl/sat_ram.sv
// ---------------------------------------------------------------------------
// sat_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module sat_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hw/rtl/sat_seq.sv
// ---------------------------------------------------------------------------
// sat_seq
// Request sequencer: drives the grid memory for write, read, build, query
// and clear, and accumulates the result.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module sat_seq import sat_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  sat_in_t              in_data,
  input  logic [CFG_W-1:0]     cfg_rows,
  input  logic [CFG_W-1:0]     cfg_cols,
  input  logic                 res_free,
  output sat_res_t             res,
  output sat_ram_req_t         ram_req,
  input  logic [VAL_W-1:0]     rdata
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CLEAR = 4'd1;
  localparam logic [3:0] S_WRC   = 4'd2;
  localparam logic [3:0] S_RD0   = 4'd3;
  localparam logic [3:0] S_RD1   = 4'd4;
  localparam logic [3:0] S_BCELL = 4'd5;
  localparam logic [3:0] S_BUP   = 4'd6;
  localparam logic [3:0] S_BWR   = 4'd7;
  localparam logic [3:0] S_Q0    = 4'd8;
  localparam logic [3:0] S_Q1    = 4'd9;
  localparam logic [3:0] S_Q2    = 4'd10;
  localparam logic [3:0] S_Q3    = 4'd11;
  localparam logic [3:0] S_Q4    = 4'd12;
  localparam logic [3:0] S_RESP  = 4'd13;

  logic [3:0]        state_r,   state_nxt;
  sat_in_t           req_r,     req_nxt;
  logic [VAL_W-1:0]  acc_r,     acc_nxt;
  logic              err_r,     err_nxt;
  logic [CRD_W-1:0]  br_r,      br_nxt;
  logic [CRD_W-1:0]  bc_r,      bc_nxt;
  logic [VAL_W-1:0]  rowacc_r,  rowacc_nxt;
  logic [ADDR_W-1:0] clr_cnt_r, clr_cnt_nxt;
  logic              clr_op_r,  clr_op_nxt;

  logic [CFG_W-1:0]  used_h;
  logic [CFG_W-1:0]  used_w;
  logic              rw_ok;
  logic              q_ok;
  logic              last_col;
  logic              last_row;
  logic [VAL_W-1:0]  up_term;

  assign used_h = used_size(cfg_rows, MAX_ROWS);
  assign used_w = used_size(cfg_cols, MAX_COLS);

  assign rw_ok = ({1'b0, in_data.row} < used_h) && ({1'b0, in_data.col} < used_w);
  assign q_ok  = ({1'b0, in_data.row2} < used_h) && ({1'b0, in_data.col2} < used_w) &&
                 (in_data.row <= in_data.row2) && (in_data.col <= in_data.col2);

  assign last_col = ({1'b0, bc_r} + CFG_W'(1)) == used_w;
  assign last_row = ({1'b0, br_r} + CFG_W'(1)) == used_h;
  // Top row has no cell above it
  assign up_term  = (br_r == '0) ? '0 : rdata;

  always_comb begin
    state_nxt   = state_r;
    req_nxt     = req_r;
    acc_nxt     = acc_r;
    err_nxt     = err_r;
    br_nxt      = br_r;
    bc_nxt      = bc_r;
    rowacc_nxt  = rowacc_r;
    clr_cnt_nxt = clr_cnt_r;
    clr_op_nxt  = clr_op_r;
    in_ready    = 1'b0;
    ram_req     = '0;
    res.valid             = 1'b0;
    res.data.result_value = acc_r;
    res.data.status       = err_r;

    case (state_r)
      S_CLEAR: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = clr_cnt_r;
        ram_req.wdata = '0;
        clr_cnt_nxt   = clr_cnt_r + ADDR_W'(1);
        if (clr_cnt_r == ADDR_W'(DEPTH - 1)) begin
          clr_op_nxt = 1'b0;
          state_nxt  = clr_op_r ? S_RESP : S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          req_nxt = in_data;
          acc_nxt = '0;
          err_nxt = 1'b0;
          case (in_data.opcode)
            OP_WRITE: begin
              if (rw_ok) begin
                state_nxt = S_WRC;
              end else begin
                err_nxt   = 1'b1;
                state_nxt = S_RESP;
              end
            end
            OP_READ: begin
              if (rw_ok) begin
                state_nxt = S_RD0;
              end else begin
                err_nxt   = 1'b1;
                state_nxt = S_RESP;
              end
            end
            OP_BUILD: begin
              br_nxt    = '0;
              bc_nxt    = '0;
              state_nxt = S_BCELL;
            end
            OP_QUERY: begin
              if (q_ok) begin
                state_nxt = S_Q0;
              end else begin
                err_nxt   = 1'b1;
                state_nxt = S_RESP;
              end
            end
            OP_CLEAR: begin
              clr_cnt_nxt = '0;
              clr_op_nxt  = 1'b1;
              state_nxt   = S_CLEAR;
            end
            default: begin
              state_nxt = S_RESP;
            end
          endcase
        end
      end
      S_WRC: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = cell_addr(req_r.row, req_r.col);
        ram_req.wdata = req_r.value;
        state_nxt     = S_RESP;
      end
      S_RD0: begin
        ram_req.raddr = cell_addr(req_r.row, req_r.col);
        state_nxt     = S_RD1;
      end
      S_RD1: begin
        acc_nxt   = rdata;
        state_nxt = S_RESP;
      end
      S_BCELL: begin
        ram_req.raddr = cell_addr(br_r, bc_r);
        state_nxt     = S_BUP;
      end
      S_BUP: begin
        // Fetch the finished entry above; keep a running sum of raw cells in this row
        ram_req.raddr = cell_addr(br_r - CRD_W'(1), bc_r);
        rowacc_nxt    = ((bc_r == '0) ? '0 : rowacc_r) + rdata;
        state_nxt     = S_BWR;
      end
      S_BWR: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = cell_addr(br_r, bc_r);
        ram_req.wdata = up_term + rowacc_r;
        state_nxt     = S_BCELL;
        if (last_col) begin
          bc_nxt = '0;
          if (last_row) begin
            state_nxt = S_RESP;
          end else begin
            br_nxt = br_r + CRD_W'(1);
          end
        end else begin
          bc_nxt = bc_r + CRD_W'(1);
        end
      end
      S_Q0: begin
        ram_req.raddr = cell_addr(req_r.row2, req_r.col2);
        state_nxt     = S_Q1;
      end
      S_Q1: begin
        ram_req.raddr = cell_addr(req_r.row - CRD_W'(1), req_r.col2);
        acc_nxt       = rdata;
        state_nxt     = S_Q2;
      end
      S_Q2: begin
        ram_req.raddr = cell_addr(req_r.row2, req_r.col - CRD_W'(1));
        acc_nxt       = acc_r - ((req_r.row == '0) ? '0 : rdata);
        state_nxt     = S_Q3;
      end
      S_Q3: begin
        ram_req.raddr = cell_addr(req_r.row - CRD_W'(1), req_r.col - CRD_W'(1));
        acc_nxt       = acc_r - ((req_r.col == '0) ? '0 : rdata);
        state_nxt     = S_Q4;
      end
      S_Q4: begin
        acc_nxt   = acc_r + (((req_r.row == '0) || (req_r.col == '0)) ? '0 : rdata);
        state_nxt = S_RESP;
      end
      S_RESP: begin
        // Hold until the output slot is free
        if (res_free) begin
          res.valid = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLEAR;
      clr_cnt_r <= '0;
      clr_op_r  <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      clr_cnt_r <= clr_cnt_nxt;
      clr_op_r  <= clr_op_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r    <= req_nxt;
    acc_r    <= acc_nxt;
    err_r    <= err_nxt;
    br_r     <= br_nxt;
    bc_r     <= bc_nxt;
    rowacc_r <= rowacc_nxt;
  end

  `SAT_ASSERT_IMP(a_build_in_area, state_r == S_BWR,
                  ({1'b0, br_r} < used_h) && ({1'b0, bc_r} < used_w),
                  "build write outside the used area")
  `SAT_ASSERT_NXT(a_resp_to_idle, res.valid, state_r == S_IDLE,
                  "sequencer did not return to idle after a result")
  `SAT_ASSERT_NXT(a_clear_advance,
                  (state_r == S_CLEAR) && (clr_cnt_r != ADDR_W'(DEPTH - 1)),
                  clr_cnt_r == $past(clr_cnt_r) + ADDR_W'(1),
                  "clearing pass skipped or stalled")
  `SAT_ASSERT_IMP(a_err_zero, res.valid && res.data.status, res.data.result_value == '0,
                  "error result carries a non-zero value")

endmodule

>>> hw/rtl/summed_area_table_2d.sv
// Throughput: one request at a time; a new request is taken once the previous one
// has reached the output register, set by the single read port of the grid memory.
// Build reads each used cell and the entry above, then writes it; clear zeroes the grid.
// Reset: synchronous, active low; afterwards a clearing pass zeroes all 4096 entries of
// the grid before the first request is taken. Size registers reset to 64.
// ---------------------------------------------------------------------------
// summed_area_table_2d
// Grid of signed 64-bit cells with in-place summed-area table build and
// rectangle-sum queries.
// ---------------------------------------------------------------------------
module summed_area_table_2d import sat_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  sat_in_t          in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output sat_out_t         out_data,
  input  logic             cfg_we,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0] cfg_wdata
);

  logic [CFG_W-1:0] rows_r;
  logic [CFG_W-1:0] cols_r;
  logic             out_valid_r;
  sat_out_t         out_data_r;

  sat_res_t         res;
  sat_ram_req_t     ram_req;
  logic [VAL_W-1:0] rdata;
  logic             res_free;

  assign res_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r <= CFG_W'(64);
      cols_r <= CFG_W'(64);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ROWS_IN_USE: rows_r <= cfg_wdata;
        REG_COLS_IN_USE: cols_r <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res.valid) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid) begin
      out_data_r <= res.data;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  sat_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .cfg_rows (rows_r),
    .cfg_cols (cols_r),
    .res_free (res_free),
    .res      (res),
    .ram_req  (ram_req),
    .rdata    (rdata)
  );

  sat_ram #(
    .WIDTH (VAL_W),
    .DEPTH (DEPTH)
  ) u_grid (
    .clk   (clk),
    .we    (ram_req.we),
    .waddr (ram_req.waddr),
    .wdata (ram_req.wdata),
    .raddr (ram_req.raddr),
    .rdata (rdata)
  );

endmodule
